// ===== design/bo3_pkg.sv =====
package bo3_pkg;

	localparam int DEF_MAX_COLUMNS = 2048;
	localparam int DEF_SAMPLE_BITS = 16;

	// fixed field and register widths
	localparam int SAMPLE_W    = 16;
	localparam int LEVEL_W     = 16;
	localparam int THR_W       = 16;
	localparam int COLS_REG_W  = 12;
	localparam int ROW_W       = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 3 * SAMPLE_W;

	localparam int ROW_LIMIT   = 4096;

	localparam logic [COLS_REG_W-1:0] COLS_RESET = COLS_REG_W'(640);
	localparam logic [ROW_W-1:0]      ROWS_RESET = ROW_W'(480);
	localparam logic [THR_W-1:0]      THR_RESET  = THR_W'(32767);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS   = 2'd0,
		REG_ROWS      = 2'd1,
		REG_THRESHOLD = 2'd2
	} reg_idx_t;

	// per-word control decided when the word is taken
	typedef struct packed {
		logic act;   // word moves the windows one position
		logic emit;  // word gives a result
		logic last;  // result closes the frame
		logic intm;  // erosion center is inside the frame ring
		logic intk;  // dilation center is inside the frame ring
	} ctl_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               last;
	} res_t;

endpackage

// ===== design/bo3_ctrl.sv =====
module bo3_ctrl import bo3_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	localparam int COL_W = $clog2(MAX_COLUMNS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_cmd,
	input  logic                  item_accept,
	output ctl_t                  ctl,
	output logic [COL_W-1:0]      col,
	output logic [THR_W-1:0]      thr
);

	localparam int CW    = $clog2(MAX_COLUMNS + 1);
	localparam int CW1   = CW + 1;
	localparam int CMP_W = (CW > COLS_REG_W) ? CW : COLS_REG_W;
	localparam int RW1   = ROW_W + 1;

	logic [COLS_REG_W-1:0] cols_q;
	logic [ROW_W-1:0]      rows_q;
	logic [THR_W-1:0]      thr_q;
	logic [COL_W-1:0]      in_col_q;
	logic [ROW_W-1:0]      in_row_q;
	logic [COL_W-1:0]      k_col_q;
	logic [ROW_W-2:0]      k_row_q;

	logic [CMP_W-1:0] cols_ext;
	logic [CW-1:0]    c;
	logic [ROW_W-1:0] r;
	logic pix_ok, flush_ok, pix_emit, act, emit, last;
	logic in_col_last, k_col_last, k_row_last;
	logic kc2, kc3, kr2, kr3;
	logic geom_wr, restart;

	assign cols_ext = CMP_W'(cols_q);

	always_comb begin
		if (cols_ext < CMP_W'(3)) begin
			c = CW'(3);
		end else if (cols_ext > CMP_W'(MAX_COLUMNS)) begin
			c = CW'(MAX_COLUMNS);
		end else begin
			c = CW'(cols_ext);
		end
		if (rows_q < ROW_W'(3)) begin
			r = ROW_W'(3);
		end else if (rows_q > ROW_W'(ROW_LIMIT)) begin
			r = ROW_W'(ROW_LIMIT);
		end else begin
			r = rows_q;
		end
	end

	assign in_col_last = CW'(in_col_q) == c - CW'(1);
	assign k_col_last  = CW'(k_col_q) == c - CW'(1);
	assign k_row_last  = ROW_W'(k_row_q) == r - ROW_W'(1);

	assign kc2 = CW1'(k_col_q) + CW1'(2) <= CW1'(c);
	assign kc3 = CW1'(k_col_q) + CW1'(3) <= CW1'(c);
	assign kr2 = RW1'(k_row_q) + RW1'(2) <= RW1'(r);
	assign kr3 = RW1'(k_row_q) + RW1'(3) <= RW1'(r);

	// pixels past the frame end and flushes before it are dropped
	assign pix_ok   = !item_cmd && (in_row_q < r);
	assign flush_ok = item_cmd && !(in_row_q < r) && (ROW_W'(k_row_q) < r);
	// first result once two rows and three pixels are in
	assign pix_emit = pix_ok && ((in_row_q >= ROW_W'(3)) ||
		((in_row_q == ROW_W'(2)) && (in_col_q >= COL_W'(2))));

	assign act  = pix_ok || flush_ok;
	assign emit = pix_emit || flush_ok;
	assign last = emit && k_col_last && k_row_last;

	always_comb begin
		ctl.act  = act;
		ctl.emit = emit;
		ctl.last = last;
		ctl.intm = emit && kc3 && kr3;
		ctl.intk = emit && (k_row_q != '0) && kr2 && (k_col_q != '0) && kc2;
	end

	assign col = in_col_q;
	assign thr = thr_q;

	assign geom_wr = cfg_we && ((cfg_index == REG_COLUMNS) || (cfg_index == REG_ROWS));
	assign restart = geom_wr || (item_accept && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
			thr_q  <= THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMNS:   cols_q <= cfg_data[COLS_REG_W-1:0];
				REG_ROWS:      rows_q <= cfg_data[ROW_W-1:0];
				REG_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			k_col_q  <= '0;
			k_row_q  <= '0;
		end else if (restart) begin
			in_col_q <= '0;
			in_row_q <= '0;
			k_col_q  <= '0;
			k_row_q  <= '0;
		end else if (item_accept && act) begin
			if (in_col_last) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + ROW_W'(1);
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end
			if (emit) begin
				if (k_col_last) begin
					k_col_q <= '0;
					k_row_q <= k_row_q + (ROW_W-1)'(1);
				end else begin
					k_col_q <= k_col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

// ===== design/bo3_linebuf.sv =====
module bo3_linebuf import bo3_pkg::*; #(
	parameter int DEPTH = DEF_MAX_COLUMNS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_bit,
	output logic          up1,
	output logic          up2
);

	// each entry holds the bit one row up (0) and two rows up (1)
	logic [1:0] mem [DEPTH];
	logic [1:0] rd_q;

	// the write stage still holds its own read word, so the rows shift down here
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {rd_q[0], wr_bit};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign up1 = rd_q[0];
	assign up2 = rd_q[1];

endmodule

// ===== design/bo3_outbuf.sv =====
module bo3_outbuf import bo3_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  res_t               res,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [LEVEL_W-1:0] m_tdata,
	output logic               m_tlast,
	output logic               room
);

	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;
	logic take;

	assign take = m_tready || !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.level;
	assign m_tlast  = out_q.last;
	assign room     = !skid_v_q;

endmodule

// ===== design/binary_opening_3x3.sv =====
// 3x3 binary opening of an RGB pixel stream, one word per clock. Each pixel is
// thresholded on (r+g+b)/3 < dark_threshold, eroded and then dilated over a 3x3
// neighborhood; the outermost ring of the frame counts as white. A result word
// (level 0 or full scale, tlast on the frame's last pixel) leaves for input
// pixel n once pixel n + 2*columns + 2 is in, so after the last pixel of a
// frame send 2*columns + 2 flush words (tuser = 1) to drain it. The datapath is
// four register stages plus an output register with one skid entry; it takes a
// word every cycle and stops only while that skid entry is occupied. Two
// MAX_COLUMNS x 2-bit line memories (threshold bits and eroded bits) hold the
// rows above. Geometry writes restart the frame; write config only when idle.
module binary_opening_3x3 import bo3_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in
	input  logic                  s_tuser,   // cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [LEVEL_W-1:0]    m_tdata,   // level_out
	output logic                  m_tlast    // frame_last
);

	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int SUM_W  = SAMPLE_BITS + 2;
	localparam int THR3_W = THR_W + 2;
	localparam logic [LEVEL_W-1:0] WHITE = LEVEL_W'((32'd1 << SAMPLE_BITS) - 32'd1);

	logic adv, accept;
	ctl_t ctl_in;
	logic [COL_W-1:0] col_in;
	logic [THR_W-1:0] thr;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [COL_W-1:0] col_s1, col_s2, col_s3;
	logic [SAMPLE_BITS-1:0] red_s1, green_s1, blue_s1;
	logic dark_s2;

	logic [SUM_W-1:0]  sum;
	logic [THR3_W-1:0] thr3;
	logic dup1, dup2, eup1, eup2;
	logic [8:0] dwin_q, ewin_q;
	logic ero_s3;
	res_t res;
	logic room;

	assign adv      = room;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	bo3_ctrl #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_cmd   (s_tuser),
		.item_accept(accept),
		.ctl        (ctl_in),
		.col        (col_in),
		.thr        (thr)
	);

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s1 <= accept ? ctl_in : '0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1   <= col_in;
			red_s1   <= s_tdata[SAMPLE_BITS-1:0];
			green_s1 <= s_tdata[SAMPLE_W +: SAMPLE_BITS];
			blue_s1  <= s_tdata[2*SAMPLE_W +: SAMPLE_BITS];
			col_s2   <= col_s1;
			col_s3   <= col_s2;
			dark_s2  <= THR3_W'(sum) < thr3;
		end
	end

	// floor(sum/3) < thr is the same as sum < 3*thr
	assign sum  = SUM_W'(red_s1) + SUM_W'(green_s1) + SUM_W'(blue_s1);
	assign thr3 = THR3_W'(thr) + (THR3_W'(thr) << 1);

	// stage 2: threshold bit with the two rows above
	bo3_linebuf #(
		.DEPTH(MAX_COLUMNS)
	) u_dark_lines (
		.clk    (clk),
		.rd_en  (adv && ctl_s1.act),
		.rd_addr(col_s1),
		.wr_en  (adv && ctl_s2.act),
		.wr_addr(col_s2),
		.wr_bit (dark_s2),
		.up1    (dup1),
		.up2    (dup2)
	);

	// stage 3: erosion over the 3x3 threshold window
	bo3_linebuf #(
		.DEPTH(MAX_COLUMNS)
	) u_eroded_lines (
		.clk    (clk),
		.rd_en  (adv && ctl_s2.act),
		.rd_addr(col_s2),
		.wr_en  (adv && ctl_s3.act),
		.wr_addr(col_s3),
		.wr_bit (ero_s3),
		.up1    (eup1),
		.up2    (eup2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwin_q <= '0;
			ewin_q <= '0;
		end else if (adv) begin
			if (ctl_s2.act) begin
				dwin_q <= {dwin_q[5:0], dup2, dup1, dark_s2};
			end
			if (ctl_s3.act) begin
				ewin_q <= {ewin_q[5:0], eup2, eup1, ero_s3};
			end
		end
	end

	// window wraps across rows only at ring positions, which the masks clear
	assign ero_s3 = ctl_s3.intm && (&dwin_q);

	// stage 4: dilation over the eroded window
	always_comb begin
		res.level = (ctl_s4.intk && (|ewin_q)) ? '0 : WHITE;
		res.last  = ctl_s4.last;
	end

	bo3_outbuf u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (adv && ctl_s4.emit),
		.res     (res),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.room    (room)
	);

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import bo3_pkg::*;

	localparam int RING_LEN = 2 * DEF_MAX_COLUMNS + 3;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_WORDS = 750;
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;
	// index with no register behind it, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_WHITE = LEVEL_W'((1 << DEF_SAMPLE_BITS) - 1);

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               last;
	} opened_px_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_COLUMNS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // red_in, green_in, blue_in
	logic                  s_tuser = 1'b0;  // cmd
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [LEVEL_W-1:0]    m_tdata;         // level_out
	logic                  m_tlast;         // frame_last

	binary_opening_3x3 uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// opening model state
	logic [COLS_REG_W-1:0] cols_reg;
	logic [ROW_W-1:0]      rows_reg;
	logic [THR_W-1:0]      thr_reg;
	bit                    dark_ring [RING_LEN];
	bit                    eroded_ring [RING_LEN];
	int unsigned           px_col, px_row, out_idx;
	opened_px_t            expected_px [$];

	// geometry as the stimulus side sees it
	int unsigned frame_cols = COLS_RESET;
	int unsigned frame_rows = ROWS_RESET;
	int unsigned frame_thr = THR_RESET;

	int send_idle_pct = 29;
	int recv_idle_pct = 70;
	int unsigned mismatches = 0;
	int unsigned words_in = 0;
	int unsigned words_counted = 0;
	int unsigned results_checked = 0;
	int unsigned frames_done = 0;
	int unsigned settings_used = 0;
	int unsigned stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic bit inner_px(int unsigned pos, int unsigned c, int unsigned r);
		return (pos / c >= 1) && (pos / c + 1 < r) && (pos % c >= 1) && (pos % c + 1 < c);
	endfunction

	// erode the pixel one row and one column ahead, then dilate around out_idx
	function automatic void emit_opened(int unsigned c, int unsigned r);
		int unsigned total, m, p;
		bit hit;
		opened_px_t px;
		total = c * r;
		m = out_idx + c + 1;
		if (m < total) begin
			hit = inner_px(m, c, r);
			for (int dr = 0; dr < 3; dr++) begin
				for (int dc = 0; dc < 3; dc++) begin
					if (hit && !dark_ring[(m - c - 1 + dr * c + dc) % RING_LEN])
						hit = 1'b0;
				end
			end
			eroded_ring[m % RING_LEN] = hit;
		end
		hit = 1'b0;
		if (inner_px(out_idx, c, r)) begin
			for (int dr = 0; dr < 3; dr++) begin
				for (int dc = 0; dc < 3; dc++) begin
					p = out_idx - c - 1 + dr * c + dc;
					if (inner_px(p, c, r) && eroded_ring[p % RING_LEN])
						hit = 1'b1;
				end
			end
		end
		px.level = hit ? '0 : LEVEL_WHITE;
		px.last = (out_idx + 1 == total);
		expected_px.push_back(px);
		out_idx++;
		if (out_idx >= total) begin
			px_col = 0;
			px_row = 0;
			out_idx = 0;
		end
	endfunction

	function automatic void take_word(logic cmd, logic [IN_DATA_W-1:0] data);
		int unsigned c, r, n, red, green, blue, gray;
		c = clamp_dim(cols_reg, 3, DEF_MAX_COLUMNS);
		r = clamp_dim(rows_reg, 3, ROW_LIMIT);
		if (cmd == CMD_FLUSH) begin
			if (px_row >= r && out_idx < c * r)
				emit_opened(c, r);
		end else if (px_row < r) begin
			red = data[SAMPLE_W-1:0];
			green = data[2*SAMPLE_W-1:SAMPLE_W];
			blue = data[3*SAMPLE_W-1:2*SAMPLE_W];
			gray = (red + green + blue) / 3;
			n = px_row * c + px_col;
			dark_ring[n % RING_LEN] = (gray < thr_reg);
			px_col++;
			if (px_col >= c) begin
				px_col = 0;
				px_row++;
			end
			if (n >= 2 * c + 2)
				emit_opened(c, r);
			else if (n >= c + 1)
				eroded_ring[n % RING_LEN] = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_reg = COLS_RESET;
			rows_reg = ROWS_RESET;
			thr_reg = THR_RESET;
			px_col = 0;
			px_row = 0;
			out_idx = 0;
			stall_cycles = 0;
			for (int i = 0; i < RING_LEN; i++) begin
				dark_ring[i] = 1'b0;
				eroded_ring[i] = 1'b0;
			end
		end else begin
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (m_tlast === 1'b1)
					frames_done++;
				if (expected_px.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, level %h last %b",
						$time, m_tdata, m_tlast);
				end else begin
					if (m_tdata !== expected_px[0].level) begin
						mismatches++;
						$display("%0t: level expected %h actual %h",
							$time, expected_px[0].level, m_tdata);
					end
					if (m_tlast !== expected_px[0].last) begin
						mismatches++;
						$display("%0t: frame_last expected %b actual %b",
							$time, expected_px[0].last, m_tlast);
					end
					void'(expected_px.pop_front());
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_COLUMNS: begin
						cols_reg = cfg_data[COLS_REG_W-1:0];
						px_col = 0;
						px_row = 0;
						out_idx = 0;
					end
					REG_ROWS: begin
						rows_reg = cfg_data[ROW_W-1:0];
						px_col = 0;
						px_row = 0;
						out_idx = 0;
					end
					REG_THRESHOLD: thr_reg = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				words_in++;
				take_word(s_tuser, s_tdata);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_word(logic cmd, logic [IN_DATA_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_px.size() != 0)
			@(posedge clk);
		// words that give no result may still be in the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] cols_word, logic [CFG_DATA_W-1:0] rows_word,
			logic [CFG_DATA_W-1:0] thr_word);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_COLUMNS;
		cfg_data <= cols_word;
		@(posedge clk);
		cfg_index <= REG_ROWS;
		cfg_data <= rows_word;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= CFG_DATA_W'($urandom());
		@(posedge clk);
		cfg_index <= REG_THRESHOLD;
		cfg_data <= thr_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_cols = clamp_dim(cols_word[COLS_REG_W-1:0], 3, DEF_MAX_COLUMNS);
		frame_rows = clamp_dim(rows_word[ROW_W-1:0], 3, ROW_LIMIT);
		frame_thr = thr_word[THR_W-1:0];
		settings_used++;
	endtask

	// pixel that lands on the requested side of the threshold, with some pure noise
	function automatic logic [IN_DATA_W-1:0] make_pixel(int unsigned dark_pct);
		logic [SAMPLE_W-1:0] red, green, blue;
		if ($urandom_range(99) < 10)
			return IN_DATA_W'({$urandom(), $urandom()});
		if ($urandom_range(99) < dark_pct && frame_thr != 0) begin
			red = SAMPLE_W'($urandom_range(frame_thr - 1, 0));
			green = SAMPLE_W'($urandom_range(frame_thr - 1, 0));
			blue = SAMPLE_W'($urandom_range(frame_thr - 1, 0));
		end else begin
			red = SAMPLE_W'($urandom_range(65535, frame_thr));
			green = SAMPLE_W'($urandom_range(65535, frame_thr));
			blue = SAMPLE_W'($urandom_range(65535, frame_thr));
		end
		return {blue, green, red};
	endfunction

	// a frame cut short (pixels below the frame size) is left open, no drain
	task automatic send_frame(int unsigned dark_pct, int unsigned pixels, bit noisy);
		int unsigned i;
		for (i = 0; i < pixels; i++) begin
			if (noisy && $urandom_range(99) < 4)
				send_word(CMD_FLUSH, IN_DATA_W'({$urandom(), $urandom()}));
			send_word(CMD_PIXEL, make_pixel(dark_pct));
			words_counted++;
		end
		if (pixels < frame_cols * frame_rows)
			return;
		for (i = 0; i < 2 * frame_cols + 2; i++) begin
			if (noisy && $urandom_range(99) < 4)
				send_word(CMD_PIXEL, make_pixel(50));
			send_word(CMD_FLUSH, IN_DATA_W'({$urandom(), $urandom()}));
			words_counted++;
		end
		if (noisy && $urandom_range(99) < 25)
			send_word(CMD_FLUSH, IN_DATA_W'({$urandom(), $urandom()}));
	endtask

	task automatic test_reset_defaults();
		send_idle_pct = 29;
		recv_idle_pct = 70;
		// start of the 640 wide default frame, too short for any result to leave
		send_frame(85, 120, 1'b1);
		send_word(CMD_FLUSH, '0);
	endtask

	task automatic test_directed_corners();
		logic [IN_DATA_W-1:0] px [12];
		px = '{
			{16'h0000, 16'h0000, 16'h0000},
			{16'hFFFE, 16'hFFFE, 16'hFFFE},
			{16'hFFFD, 16'hFFFF, 16'hFFFF},
			{16'hFFFF, 16'hFFFF, 16'hFFFF},
			{16'hFFFE, 16'hFFFF, 16'hFFFF},
			{16'h0000, 16'h0000, 16'hFFFF},
			{16'h0000, 16'hFFFF, 16'h0000},
			{16'hFFFF, 16'h0000, 16'h0000},
			{16'h0000, 16'hFFFF, 16'hFFFF},
			{16'h0003, 16'h0002, 16'h0001},
			{16'h8000, 16'h4000, 16'hC000},
			{16'h0001, 16'h0001, 16'h0001}
		};
		send_idle_pct = 29;
		recv_idle_pct = 70;
		// 4x3 frame, full-scale threshold; the gray == threshold pixel at the
		// end of row 0 stays white so only the left interior pixel erodes
		configure(16'd4, 16'd3, 16'hFFFF);
		send_word(CMD_FLUSH, '0);
		foreach (px[i])
			send_word(CMD_PIXEL, px[i]);
		repeat (5) send_word(CMD_FLUSH, '1);
		send_word(CMD_PIXEL, '0);
		repeat (5) send_word(CMD_FLUSH, '0);
		send_word(CMD_FLUSH, '1);
	endtask

	task automatic test_random_frames();
		int unsigned first, done, cols, rows, pixels;
		logic [CFG_DATA_W-1:0] cols_word, rows_word, thr_word;
		first = words_counted;
		while (words_counted - first < RANDOM_WORDS) begin
			done = words_counted - first;
			if (done >= 2 * RANDOM_WORDS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (done >= RANDOM_WORDS / 3) begin
				send_idle_pct = 70;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 29;
				recv_idle_pct = 70;
			end
			cols = ($urandom_range(99) < 10) ? $urandom_range(40, 10) : $urandom_range(9, 3);
			rows = $urandom_range(8, 3);
			cols_word = CFG_DATA_W'($urandom());
			cols_word[COLS_REG_W-1:0] = COLS_REG_W'(cols);
			rows_word = CFG_DATA_W'($urandom());
			rows_word[ROW_W-1:0] = ROW_W'(rows);
			case ($urandom_range(9))
				0: thr_word = '0;
				1: thr_word = '1;
				default: thr_word = CFG_DATA_W'($urandom());
			endcase
			configure(cols_word, rows_word, thr_word);
			repeat ($urandom_range(3, 1)) begin
				pixels = frame_cols * frame_rows;
				if ($urandom_range(99) < 10)
					pixels = $urandom_range(pixels - 1, 1);
				send_frame(($urandom_range(3) == 0) ? $urandom_range(100) : $urandom_range(95, 70),
					pixels, 1'b1);
				if (pixels < frame_cols * frame_rows)
					break;
			end
		end
	endtask

	task automatic test_geometry_extremes();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// both sizes below the minimum, clamped up to three
		configure(16'hF001, 16'hE000, 16'h8000);
		send_frame(90, frame_cols * frame_rows, 1'b0);
		// widest row, cut short: nothing may leave before two full rows are in
		configure(16'hFFFF, 16'd3, 16'h7FFF);
		send_frame(85, 120, 1'b0);
		// tallest frame, cut short after fifty rows and left open at the end of the test
		configure(16'd3, 16'hFFFF, 16'hC000);
		send_frame(85, 3 * 50, 1'b0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_corners();
		test_random_frames();
		test_geometry_extremes();
		wait_idle();
		$display("covered %0d geometry settings and %0d closed frames",
			settings_used, frames_done);
		$display("%0d words taken in, %0d result words compared", words_in, results_checked);
		if (mismatches == 0 && expected_px.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
